// File: rtl/itgd_pkg.sv
// shared types and constants of the integer to grouped decimal text unit
`default_nettype none
package itgd_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = 1;
	localparam int unsigned QCNT_W = 2;

	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned DIG_IDX_W = 4;

	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int unsigned RECIP_SHIFT = 35;

	localparam logic [15:0] DIGIT_ZERO = 16'd48;
	localparam logic [15:0] MINUS_RESET = 16'd45;
	localparam logic [15:0] GROUP_RESET = 16'd44;

	localparam logic REG_MINUS = 1'b0;
	localparam logic REG_GROUP = 1'b1;

	typedef struct packed {
		logic [31:0] mag;
		logic        neg;
		logic        grouped;
	} item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

// File: rtl/itgd_front.sv
// input side: sign and magnitude split and a two-word queue towards the converter
`default_nettype none
module itgd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  wire  signed [31:0]  value,
	input  wire                 func,
	output logic                item_valid,
	input  wire                 item_ready,
	output itgd_pkg::item_t     item
);
	import itgd_pkg::*;

	item_t             q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              wr_en;
	logic              rd_en;
	item_t             new_item;

	always_comb begin
		new_item.neg     = value[31];
		new_item.mag     = value[31] ? (32'd0 - 32'(value)) : 32'(value);
		new_item.grouped = func;
	end

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign item_valid = (count_q != '0);
	assign item       = q_mem[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/itgd_back.sv
// converter: digit extraction by reciprocal multiply, then character emission
`default_nettype none
module itgd_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	input  itgd_pkg::item_t     item,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire                 cfg_index,
	input  wire  [15:0]         cfg_data,
	output logic                empty,
	input  wire                 pop,
	output logic [15:0]         out_char,
	output logic                last
);
	import itgd_pkg::*;

	state_t               state_q;
	state_t               state_d;
	logic [31:0]          mag_q;
	logic [3:0]           digit_q [NUM_DIGITS];
	logic [DIG_IDX_W-1:0] idx_q;
	logic                 neg_q;
	logic                 sep_q;
	logic                 grp_q;
	logic                 oval_q;
	logic [15:0]          ochar_q;
	logic                 olast_q;
	logic [15:0]          minus_q;
	logic [15:0]          group_q;

	logic [63:0]          prod;
	logic [31:0]          quot;
	logic [3:0]           rem;
	logic                 conv_done;
	logic                 emit_go;
	logic                 load;
	logic [15:0]          emit_char;
	logic                 emit_last;
	logic                 group_point;

	assign prod      = 64'(mag_q) * 64'(RECIP_TEN);
	assign quot      = 32'(prod >> RECIP_SHIFT);
	assign rem       = 4'(mag_q - ((quot << 3) + (quot << 1)));
	assign conv_done = (quot == 32'd0);

	assign group_point = grp_q && ((idx_q == DIG_IDX_W'(3)) || (idx_q == DIG_IDX_W'(6))
		|| (idx_q == DIG_IDX_W'(9)));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (conv_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_go && !neg_q && !sep_q && (idx_q == '0)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the state machine
	always_comb begin
		item_ready = 1'b0;
		load       = 1'b0;
		emit_go    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				load       = item_valid;
			end
			ST_EMIT: begin
				emit_go = !oval_q || pop;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	always_comb begin
		emit_last = 1'b0;
		if (neg_q) begin
			emit_char = minus_q;
		end else if (sep_q) begin
			emit_char = group_q;
		end else begin
			emit_char = DIGIT_ZERO + 16'(digit_q[idx_q]);
			emit_last = (idx_q == '0);
		end
	end

	assign cfg_ready = 1'b1;
	assign empty     = !oval_q;
	assign out_char  = ochar_q;
	assign last      = olast_q;

	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= item.mag;
		end else if (state_q == ST_CONV) begin
			mag_q         <= quot;
			digit_q[idx_q] <= rem;
		end
		if (emit_go) begin
			ochar_q <= emit_char;
			olast_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			neg_q   <= 1'b0;
			sep_q   <= 1'b0;
			grp_q   <= 1'b0;
			oval_q  <= 1'b0;
			minus_q <= MINUS_RESET;
			group_q <= GROUP_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MINUS) begin
					minus_q <= cfg_data;
				end else begin
					group_q <= cfg_data;
				end
			end
			if (load) begin
				idx_q <= '0;
				neg_q <= item.neg;
				sep_q <= 1'b0;
				grp_q <= item.grouped;
			end else if (state_q == ST_CONV) begin
				if (!conv_done) begin
					idx_q <= idx_q + DIG_IDX_W'(1);
				end
			end else if (emit_go) begin
				if (neg_q) begin
					neg_q <= 1'b0;
				end else if (sep_q) begin
					sep_q <= 1'b0;
				end else if (idx_q != '0) begin
					sep_q <= group_point;
					idx_q <= idx_q - DIG_IDX_W'(1);
				end
			end
			if (emit_go) begin
				oval_q <= 1'b1;
			end else if (pop) begin
				oval_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/int_to_grouped_decimal_chars_unit.sv
// top level of the integer to grouped decimal text unit
// usage: push a signed 32-bit value with func (0 plain, 1 grouped by three)
// while full is low; each accepted word gives 1 to 14 characters, leftmost
// first, read with pop while empty is low, last marking the final one.
// a negative value starts with minus_char, grouped mode puts group_char
// between three-digit groups counted from the right.
// config: cfg_index 0 writes minus_char, 1 writes group_char; cfg_ready is
// always high; write only while the unit is idle.
// timing: an input word waits in a two-word queue, then the converter
// extracts one decimal digit at a time (1 to 10 digits, one multiply by the
// reciprocal of ten per cycle) and then emits one character per cycle while
// pop keeps up. the queue takes two further words meanwhile.
// a stalled pop holds the current character in the output register and the
// converter waits; full rises once the queue holds two words.
// reset empties the queue and output register and restores minus_char to 45
// and group_char to 44.
`default_nettype none
module int_to_grouped_decimal_chars_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	output logic               full,
	input  wire  signed [31:0] value,
	input  wire                func,
	output logic               empty,
	input  wire                pop,
	output logic [15:0]        out_char,
	output logic               last,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire                cfg_index,
	input  wire  [15:0]        cfg_data
);
	import itgd_pkg::*;

	logic  item_valid;
	logic  item_ready;
	item_t item;

	itgd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.value      (value),
		.func       (func),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	itgd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.empty      (empty),
		.pop        (pop),
		.out_char   (out_char),
		.last       (last)
	);

endmodule
`default_nettype wire
